// ===== sv/assert_macros.svh =====
// Assertion helpers used by the slot assigner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked, reset-qualified assertion.
`define SBSA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same, as an implication |=> built from the caller's antecedent and consequent.
`define SBSA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/sbsa_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbsa_pkg
// Shared types and constants of the sprite batch slot assigner.
// ---------------------------------------------------------------------------
package sbsa_pkg;

	localparam int DEF_MAX_QUADS = 1024;
	localparam int DEF_MAX_SLOTS = 32;

	localparam logic [15:0] WIN_W_RST = 16'd800;
	localparam logic [15:0] WIN_H_RST = 16'd600;

	localparam logic [1:0] OP_UV_RECT = 2'd0;
	localparam logic [1:0] OP_UNIT_UV = 2'd1;
	localparam logic [1:0] OP_FLUSH   = 2'd2;

	localparam logic [1:0] KIND_VERTEX = 2'd0;
	localparam logic [1:0] KIND_BIND   = 2'd1;
	localparam logic [1:0] KIND_DRAW   = 2'd2;

	localparam logic [0:0] REG_WIN_W = 1'd0;
	localparam logic [0:0] REG_WIN_H = 1'd1;

	localparam int DIV_DW = 33;   // dividend magnitude bits (|2*pos|)

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BIND_RD,
		ST_BIND_OUT,
		ST_DRAW,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SLOT_NEW,
		ST_DIVX_GO,
		ST_DIVX_WAIT,
		ST_DIVY_GO,
		ST_DIVY_WAIT,
		ST_MUL_X,
		ST_MUL_Y,
		ST_MUL_Y2,
		ST_VERT
	} state_t;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

	function automatic logic [31:0] sat32(input logic signed [49:0] v);
		logic [31:0] r;
		if (v > 50'sd2147483647) r = 32'h7fff_ffff;
		else if (v < -50'sd2147483648) r = 32'h8000_0000;
		else r = v[31:0];
		return r;
	endfunction

endpackage

// ===== sv/sbsa_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbsa_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module sbsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/sbsa_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbsa_div
// Bit-serial signed-by-unsigned divider, truncating toward zero.
// ---------------------------------------------------------------------------
module sbsa_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sbsa_pkg::div_ctl_t   ctl_in,     // start used
	output sbsa_pkg::div_ctl_t   ctl_out,    // done used
	input  logic signed [33:0]   dividend,
	input  logic [15:0]          divisor,
	output logic signed [33:0]   quotient
);

	localparam int CW = $clog2(sbsa_pkg::DIV_DW + 1);

	logic [sbsa_pkg::DIV_DW-1:0] mag_q;
	logic [15:0]                 rem_q;
	logic [15:0]                 den_q;
	logic                        neg_q;
	logic [CW-1:0]               cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [16:0]                 trial;
	logic                        fits;

	assign trial = {rem_q, mag_q[sbsa_pkg::DIV_DW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl_in.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(sbsa_pkg::DIV_DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			neg_q <= dividend[33];
			mag_q <= dividend[33] ? 33'(-dividend) : dividend[32:0];
			den_q <= (divisor == 16'd0) ? 16'd1 : divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(trial - {1'b0, den_q}) : trial[15:0];
			mag_q <= {mag_q[sbsa_pkg::DIV_DW-2:0], fits};
		end
	end

	assign quotient      = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
	assign ctl_out.done  = done_q;
	assign ctl_out.start = 1'b0;

endmodule

// ===== sv/sprite_batch_slot_assigner.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sprite_batch_slot_assigner
// Batches quad requests onto a table of texture slots and emits vertices.
// ---------------------------------------------------------------------------
// Usage:
//   s_* takes one request: op in s_tuser, quad fields in s_tdata. s_tready is
//   high only while the sequencer is idle; one request is in flight at a time.
//   m_* returns results: kind in m_tuser, m_tlast on the final result of the
//   request. Binds/draw come first when the batch is full or op is flush.
//   Work per request: a read and a compare state per used slot searched, two
//   serial divisions (start, 33 shift steps, done; one shared divider), the
//   ST_MUL_X, ST_MUL_Y and ST_MUL_Y2 states on the shared multiplier, and
//   ST_VERT for each vertex, plus a read and an output state per bind when a
//   flush or a full batch runs. The divider sets the floor.
//   Results go out through a single output register; a stalled receiver
//   (m_tready low) holds the sequencer in its emit state, nothing is lost.
//   Reset: window 800x600, one used slot (blank), no quads batched. The slot
//   table needs no clearing pass: entry 0 reads as zero by decode, others are
//   written before they are read.
//   Config: cfg_we writes cfg_data to register cfg_index; user: idle only, unchecked.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sprite_batch_slot_assigner #(
	parameter int MAX_QUADS = sbsa_pkg::DEF_MAX_QUADS,
	parameter int MAX_SLOTS = sbsa_pkg::DEF_MAX_SLOTS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pos_x, pos_y, size_x, size_y, texture_id, scale_x, scale_y,
	// uv_left, uv_top, uv_right, uv_bottom (32 bits each, lowest first)
	input  logic [351:0] s_tdata,
	input  logic [1:0]   s_tuser,    // op
	output logic         m_tvalid,
	input  logic         m_tready,
	// vert_x[31:0], vert_y[63:32], tex_u[95:64], tex_v[127:96],
	// slot[132:128], bound_texture[164:133], index_count[177:165], zero pad
	output logic [183:0] m_tdata,
	output logic [1:0]   m_tuser,    // kind
	output logic         m_tlast     // last
);

	localparam int SW = $clog2(MAX_SLOTS + 1);
	localparam int AW = $clog2(MAX_SLOTS);
	localparam int QW = $clog2(MAX_QUADS + 1);
	localparam int CW = (QW + 3 > 13) ? QW + 3 : 13;

	sbsa_pkg::state_t state_q, state_d;

	// batch state
	logic [SW-1:0] slots_used_q;
	logic [QW-1:0] quads_q;
	logic [SW-1:0] idx_q;
	logic [SW-1:0] slot_q;
	logic [1:0]    corner_q;
	logic [15:0]   win_w_q, win_h_q;

	// request registers
	logic [1:0]         op_q;
	logic signed [31:0] px_q, py_q, szx_q, szy_q, scx_q, scy_q;
	logic signed [31:0] ul_q, ut_q, ur_q, ub_q;
	logic [31:0]        tex_q;

	// arithmetic
	logic signed [34:0] x_q, y_q;
	logic signed [63:0] prod_q;
	logic signed [47:0] dx_q, dy_q;
	logic signed [31:0] mul_a, mul_b;

	// output register
	logic         ovalid_q;
	logic [183:0] odata_q;
	logic [1:0]   okind_q;
	logic         olast_q;

	// control
	logic               in_acc;
	logic               out_free;
	logic               emit;
	logic               full;
	logic               ram_we;
	logic [31:0]        ram_rdata;
	logic [31:0]        slot_tex;
	logic               match;
	logic               is_flush;
	sbsa_pkg::div_ctl_t div_in, div_out;
	logic signed [33:0] div_dividend;
	logic [15:0]        div_divisor;
	logic signed [33:0] quot;
	logic [CW-1:0]      cnt6;
	logic [6:0]         slot_w;
	logic [SW-1:0]      idx_nx;

	assign out_free = !ovalid_q || m_tready;
	assign full     = (quads_q >= QW'(MAX_QUADS)) || (slots_used_q >= SW'(MAX_SLOTS));
	assign is_flush = op_q[1];
	assign idx_nx   = idx_q + 1'b1;
	assign slot_tex = (idx_q == '0) ? 32'd0 : ram_rdata;   // slot 0 is the blank texture
	assign match    = slot_tex == tex_q;
	assign cnt6     = CW'(quads_q) * CW'(6);

	sbsa_ram #(.WIDTH(32), .DEPTH(MAX_SLOTS)) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slots_used_q[AW-1:0]),
		.wdata (tex_q),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// one divider serves x then y
	assign div_dividend = (state_q == sbsa_pkg::ST_DIVX_GO) ? {px_q[31], px_q, 1'b0}
	                                                        : {py_q[31], py_q, 1'b0};
	assign div_divisor  = (state_q == sbsa_pkg::ST_DIVX_GO) ? win_w_q : win_h_q;

	sbsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (div_in),
		.ctl_out  (div_out),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (quot)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sbsa_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser[1] || full) state_d = sbsa_pkg::ST_BIND_RD;
					else if (slots_used_q == SW'(1)) state_d = sbsa_pkg::ST_SLOT_NEW;
					else state_d = sbsa_pkg::ST_SRCH_RD;
				end
			end
			sbsa_pkg::ST_BIND_RD: state_d = sbsa_pkg::ST_BIND_OUT;
			sbsa_pkg::ST_BIND_OUT: begin
				if (out_free) begin
					state_d = (idx_nx == slots_used_q) ? sbsa_pkg::ST_DRAW
					                                   : sbsa_pkg::ST_BIND_RD;
				end
			end
			sbsa_pkg::ST_DRAW: begin
				if (out_free) begin
					state_d = is_flush ? sbsa_pkg::ST_IDLE : sbsa_pkg::ST_SLOT_NEW;
				end
			end
			sbsa_pkg::ST_SRCH_RD: state_d = sbsa_pkg::ST_SRCH_CMP;
			sbsa_pkg::ST_SRCH_CMP: begin
				if (match) state_d = sbsa_pkg::ST_DIVX_GO;
				else if (idx_nx == slots_used_q) state_d = sbsa_pkg::ST_SLOT_NEW;
				else state_d = sbsa_pkg::ST_SRCH_RD;
			end
			sbsa_pkg::ST_SLOT_NEW:  state_d = sbsa_pkg::ST_DIVX_GO;
			sbsa_pkg::ST_DIVX_GO:   state_d = sbsa_pkg::ST_DIVX_WAIT;
			sbsa_pkg::ST_DIVX_WAIT: if (div_out.done) state_d = sbsa_pkg::ST_DIVY_GO;
			sbsa_pkg::ST_DIVY_GO:   state_d = sbsa_pkg::ST_DIVY_WAIT;
			sbsa_pkg::ST_DIVY_WAIT: if (div_out.done) state_d = sbsa_pkg::ST_MUL_X;
			sbsa_pkg::ST_MUL_X:     state_d = sbsa_pkg::ST_MUL_Y;
			sbsa_pkg::ST_MUL_Y:     state_d = sbsa_pkg::ST_MUL_Y2;
			sbsa_pkg::ST_MUL_Y2:    state_d = sbsa_pkg::ST_VERT;
			sbsa_pkg::ST_VERT: begin
				if (out_free && corner_q == 2'd3) state_d = sbsa_pkg::ST_IDLE;
			end
			default: state_d = sbsa_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready     = 1'b0;
		ram_we       = 1'b0;
		div_in.start = 1'b0;
		div_in.done  = 1'b0;
		emit         = 1'b0;
		unique case (state_q)
			sbsa_pkg::ST_IDLE:     s_tready = 1'b1;
			sbsa_pkg::ST_SLOT_NEW: ram_we = 1'b1;
			sbsa_pkg::ST_DIVX_GO,
			sbsa_pkg::ST_DIVY_GO:  div_in.start = 1'b1;
			sbsa_pkg::ST_BIND_OUT,
			sbsa_pkg::ST_DRAW,
			sbsa_pkg::ST_VERT:     emit = out_free;
			default: ;
		endcase
	end

	assign in_acc = s_tvalid && s_tready;

	// vertex corner values
	logic signed [49:0] vx, vy;
	logic [31:0]        cu, cv;
	always_comb begin
		vx = 50'(x_q) + ((corner_q == 2'd1 || corner_q == 2'd2) ? 50'(dx_q) : 50'sd0);
		vy = 50'(y_q) + ((corner_q[1]) ? 50'(dy_q) : 50'sd0);
		if (op_q == sbsa_pkg::OP_UV_RECT) begin
			cu = (corner_q == 2'd1 || corner_q == 2'd2) ? ur_q : ul_q;
			cv = corner_q[1] ? ut_q : ub_q;
		end else begin
			cu = (corner_q == 2'd1 || corner_q == 2'd2) ? scx_q : 32'd0;
			cv = corner_q[1] ? scy_q : 32'd0;
		end
	end

	// result about to be emitted
	logic [183:0] res_data;
	logic [1:0]   res_kind;
	logic         res_last;
	always_comb begin
		res_data = '0;
		res_kind = sbsa_pkg::KIND_VERTEX;
		res_last = 1'b0;
		unique case (state_q)
			sbsa_pkg::ST_BIND_OUT: begin
				res_kind          = sbsa_pkg::KIND_BIND;
				res_data[132:128] = slot_w[4:0];
				res_data[164:133] = slot_tex;
			end
			sbsa_pkg::ST_DRAW: begin
				res_kind          = sbsa_pkg::KIND_DRAW;
				res_data[177:165] = cnt6[12:0];
				res_last          = is_flush;
			end
			default: begin
				res_kind          = sbsa_pkg::KIND_VERTEX;
				res_data[31:0]    = sbsa_pkg::sat32(vx);
				res_data[63:32]   = sbsa_pkg::sat32(vy);
				res_data[95:64]   = cu;
				res_data[127:96]  = cv;
				res_data[132:128] = slot_w[4:0];
				res_last          = corner_q == 2'd3;
			end
		endcase
	end

	// shared multiplier operands: x pair, then y pair
	assign mul_a = (state_q == sbsa_pkg::ST_MUL_X) ? szx_q : szy_q;
	assign mul_b = (state_q == sbsa_pkg::ST_MUL_X) ? scx_q : scy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sbsa_pkg::ST_IDLE;
			slots_used_q <= SW'(1);
			quads_q      <= '0;
			idx_q        <= '0;
			corner_q     <= '0;
			win_w_q      <= sbsa_pkg::WIN_W_RST;
			win_h_q      <= sbsa_pkg::WIN_H_RST;
			ovalid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					sbsa_pkg::REG_WIN_W: win_w_q <= cfg_data;
					sbsa_pkg::REG_WIN_H: win_h_q <= cfg_data;
					default: ;
				endcase
			end
			ovalid_q <= emit || (ovalid_q && !m_tready);
			if (in_acc) begin
				idx_q    <= (s_tuser[1] || full) ? '0 : SW'(1);
				corner_q <= '0;
			end
			if (state_q == sbsa_pkg::ST_BIND_OUT && emit) idx_q <= idx_nx;
			if (state_q == sbsa_pkg::ST_SRCH_CMP && !match) idx_q <= idx_nx;
			if (state_q == sbsa_pkg::ST_DRAW && emit) begin
				slots_used_q <= SW'(1);
				quads_q      <= '0;
			end
			if (state_q == sbsa_pkg::ST_SLOT_NEW) slots_used_q <= slots_used_q + 1'b1;
			if (state_q == sbsa_pkg::ST_VERT && emit) begin
				corner_q <= corner_q + 1'b1;
				if (corner_q == 2'd3) quads_q <= quads_q + 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= s_tuser;
			px_q  <= s_tdata[31:0];
			py_q  <= s_tdata[63:32];
			szx_q <= s_tdata[95:64];
			szy_q <= s_tdata[127:96];
			tex_q <= s_tdata[159:128];
			scx_q <= s_tdata[191:160];
			scy_q <= s_tdata[223:192];
			ul_q  <= s_tdata[255:224];
			ut_q  <= s_tdata[287:256];
			ur_q  <= s_tdata[319:288];
			ub_q  <= s_tdata[351:320];
		end
		if (state_q == sbsa_pkg::ST_SRCH_CMP && match) slot_q <= idx_q;
		if (state_q == sbsa_pkg::ST_SLOT_NEW) slot_q <= slots_used_q;
		if (state_q == sbsa_pkg::ST_DIVX_WAIT && div_out.done) x_q <= 35'(quot) - 35'sd65536;
		if (state_q == sbsa_pkg::ST_DIVY_WAIT && div_out.done) y_q <= 35'sd65536 - 35'(quot);
		// shared multiplier: x product, then y product; extents floor by arithmetic shift
		if (state_q == sbsa_pkg::ST_MUL_X || state_q == sbsa_pkg::ST_MUL_Y) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == sbsa_pkg::ST_MUL_Y) begin
			dx_q <= (op_q == sbsa_pkg::OP_UV_RECT) ? prod_q[63:16] : 48'(szx_q);
		end
		if (state_q == sbsa_pkg::ST_MUL_Y2) begin
			dy_q <= (op_q == sbsa_pkg::OP_UV_RECT) ? prod_q[63:16] : 48'(szy_q);
		end
		if (emit) begin
			odata_q <= res_data;
			okind_q <= res_kind;
			olast_q <= res_last;
		end
	end

	// bind results carry the index, vertices the assigned slot
	assign slot_w = (state_q == sbsa_pkg::ST_BIND_OUT) ? 7'(idx_q) : 7'(slot_q);

	assign m_tvalid = ovalid_q;
	assign m_tdata  = odata_q;
	assign m_tuser  = okind_q;
	assign m_tlast  = olast_q;

	`SBSA_ASSERT_IMP(a_busy_after_req, in_acc, !s_tready, "ready while request in flight")
	`SBSA_ASSERT_IMP(a_draw_resets, state_q == sbsa_pkg::ST_DRAW && emit,
		slots_used_q == SW'(1) && quads_q == '0, "batch not cleared by draw")
	`SBSA_ASSERT_IMP(a_quad_count, state_q == sbsa_pkg::ST_VERT && emit && corner_q == 2'd3,
		quads_q == $past(quads_q) + 1'b1, "quad count not advanced")
	`SBSA_ASSERT(a_slots_bound, slots_used_q >= SW'(1) && slots_used_q <= SW'(MAX_SLOTS),
		"slot count out of range")

endmodule
